>>> rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit partition allocator package
// Shared widths, reset constants, register indexes and request/result types.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int NUM_REGS       = 4;
    localparam int SIZE_W         = 12;
    localparam int ADDR_W         = 14;
    localparam int COUNT_W        = 3;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;
    localparam int DEF_PARTITIONS = 4;

    typedef logic [NUM_REGS-1:0][SIZE_W-1:0] size_array_t;

    localparam size_array_t SIZE_RESET = {12'd100, 12'd150, 12'd250, 12'd500};

    typedef enum logic [1:0] {
        REG_SIZE_0 = 2'd0,
        REG_SIZE_1 = 2'd1,
        REG_SIZE_2 = 2'd2,
        REG_SIZE_3 = 2'd3
    } reg_index_t;

    typedef enum logic {
        CMD_ALLOCATE = 1'b0,
        CMD_RELEASE  = 1'b1
    } command_t;

    typedef struct packed {
        command_t          command;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_base;
    } request_t;

    typedef struct packed {
        logic               success;
        logic [ADDR_W-1:0]  granted_base;
        logic [ADDR_W-1:0]  used_total;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
        logic [ADDR_W-1:0]  free_total;
        logic [ADDR_W-1:0]  free_usable_total;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ffpa_engine.sv
// ----------------------------------------------------------------------------
// First-fit partition allocator engine
// Scans all partitions in parallel, picks the first fitting or matching one,
// and computes the updated occupancy and the usage figures.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_engine #(
    parameter int PARTITIONS = ffpa_pkg::DEF_PARTITIONS
) (
    input  ffpa_pkg::request_t                             request,
    input  ffpa_pkg::size_array_t                          sizes,
    input  logic [PARTITIONS-1:0][ffpa_pkg::SIZE_W-1:0]    occ,
    output logic [PARTITIONS-1:0][ffpa_pkg::SIZE_W-1:0]    occ_update,
    output ffpa_pkg::result_t                              result
);

    logic [ffpa_pkg::ADDR_W-1:0]  addr;
    logic [ffpa_pkg::ADDR_W-1:0]  granted;
    logic [ffpa_pkg::ADDR_W-1:0]  used_total;
    logic [ffpa_pkg::ADDR_W-1:0]  usable;
    logic [ffpa_pkg::COUNT_W-1:0] used_count;
    logic                         done;

    always_comb
    begin
        addr       = '0;
        granted    = '0;
        done       = 1'b0;
        occ_update = occ;
        for (int i = 0; i < PARTITIONS; i++)
        begin
            if (!done)
            begin
                if (request.command == ffpa_pkg::CMD_ALLOCATE)
                begin
                    if ((request.request_size != '0) && (occ[i] == '0) &&
                        (sizes[i] >= request.request_size))
                    begin
                        occ_update[i] = request.request_size;
                        granted       = addr;
                        done          = 1'b1;
                    end
                end
                else if ((addr == request.release_base) && (occ[i] != '0))
                begin
                    occ_update[i] = '0;
                    done          = 1'b1;
                end
            end
            addr = addr + {2'b00, sizes[i]};
        end
    end

    always_comb
    begin
        used_total = '0;
        usable     = '0;
        used_count = '0;
        for (int i = 0; i < PARTITIONS; i++)
        begin
            if (occ_update[i] != '0)
            begin
                used_total = used_total + {2'b00, occ_update[i]};
                used_count = used_count + 3'd1;
            end
            else
            begin
                usable = usable + {2'b00, sizes[i]};
            end
        end
    end

    always_comb
    begin
        result.success           = done;
        result.granted_base      = granted;
        result.used_total        = used_total;
        result.used_count        = used_count;
        result.free_count        = ffpa_pkg::COUNT_W'(PARTITIONS) - used_count;
        result.free_total        = (addr >= used_total) ? (addr - used_total) : '0;
        result.free_usable_total = usable;
    end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// First-fit partition allocator
// Fixed partitions back to back from address zero, with first-fit allocate
// and release by start address.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// busy never rises, so a request can be taken in every cycle.
// The request is registered, evaluated in the following cycle against the
// current occupancy, and its result is registered and shown on result for
// exactly one cycle with result_valid high.
// The receiver cannot stall; each result must be taken in its cycle.
// Throughput is one request per cycle, set by the single evaluation stage
// that reads and writes the occupancy registers in the same cycle.
// The APB port writes and reads the four partition sizes at byte addresses
// 0, 4, 8 and 12; sizes should only change while no request is in flight.
// Reset marks every partition free and loads the sizes 500, 250, 150, 100.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_partition_allocator #(
    parameter int PARTITIONS = ffpa_pkg::DEF_PARTITIONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ffpa_pkg::request_t            request,
    output logic                          result_valid,
    output ffpa_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    ffpa_pkg::size_array_t                       size_reg;
    ffpa_pkg::size_array_t                       size_next;
    logic [PARTITIONS-1:0][ffpa_pkg::SIZE_W-1:0] occ_reg;
    logic [PARTITIONS-1:0][ffpa_pkg::SIZE_W-1:0] occ_next;
    logic [PARTITIONS-1:0][ffpa_pkg::SIZE_W-1:0] occ_update;
    ffpa_pkg::request_t                          req_reg;
    logic                                        req_valid_reg;
    ffpa_pkg::result_t                           result_reg;
    ffpa_pkg::result_t                           result_update;
    logic                                        result_valid_reg;
    logic                                        accept;
    logic                                        cfg_write;
    ffpa_pkg::reg_index_t                        cfg_index;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = ffpa_pkg::reg_index_t'(paddr[ffpa_pkg::PADDR_W-1:2]);

    always_comb
    begin
        size_next = size_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ffpa_pkg::REG_SIZE_0: size_next[ffpa_pkg::REG_SIZE_0] = pwdata[11:0];
                ffpa_pkg::REG_SIZE_1: size_next[ffpa_pkg::REG_SIZE_1] = pwdata[11:0];
                ffpa_pkg::REG_SIZE_2: size_next[ffpa_pkg::REG_SIZE_2] = pwdata[11:0];
                ffpa_pkg::REG_SIZE_3: size_next[ffpa_pkg::REG_SIZE_3] = pwdata[11:0];
                default:              size_next = size_reg;
            endcase
        end
    end

    assign prdata = {{(ffpa_pkg::PDATA_W - ffpa_pkg::SIZE_W){1'b0}}, size_reg[cfg_index]};

    ffpa_engine #(
        .PARTITIONS (PARTITIONS)
    ) u_ffpa_engine (
        .request    (req_reg),
        .sizes      (size_reg),
        .occ        (occ_reg),
        .occ_update (occ_update),
        .result     (result_update)
    );

    assign occ_next = req_valid_reg ? occ_update : occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg         <= ffpa_pkg::SIZE_RESET;
            occ_reg          <= '0;
            req_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg         <= size_next;
            occ_reg          <= occ_next;
            req_valid_reg    <= accept;
            result_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (req_valid_reg)
        begin
            result_reg <= result_update;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/ffpa_checker.sv
// ----------------------------------------------------------------------------
// First-fit partition allocator checker
// Port-level checks on request latency and consistency of reported results.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_checker #(
    parameter int PARTITIONS = ffpa_pkg::DEF_PARTITIONS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input ffpa_pkg::result_t result
);

    a_result_follows_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid
    ) else $error("A taken request produced no result two cycles later.");

    a_no_spurious_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !result_valid
    ) else $error("A result appeared without a matching request.");

    a_counts_cover_all: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |->
            (({1'b0, result.used_count} + {1'b0, result.free_count}) == 4'(PARTITIONS))
    ) else $error("Used and free partition counts do not add up.");

    a_refused_has_no_base: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.success) |-> (result.granted_base == '0)
    ) else $error("A refused request reported a nonzero base.");

    a_empty_has_no_usage: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && (result.used_count == '0)) |-> (result.used_total == '0)
    ) else $error("No partition is used but the used total is nonzero.");

endmodule

bind first_fit_partition_allocator ffpa_checker #(
    .PARTITIONS (PARTITIONS)
) u_ffpa_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// First-fit partition allocator testbench
// Directed and random requests with random gaps and several partition size
// settings. A local first-fit predictor gives the expected result of each
// accepted request, and every result is checked field by field in order.
// ----------------------------------------------------------------------------

module tb;

    import ffpa_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 50;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    request_t            request;
    logic                result_valid;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [SIZE_W-1:0]   part_size [NUM_REGS];
    logic [SIZE_W-1:0]   occupied [NUM_REGS];
    result_t             pending_results [$];
    int                  error_count;
    int                  idle_cycles;
    bit                  no_gaps;

    first_fit_partition_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic result_t first_fit_step(request_t r);
        result_t res;
        int      base;
        int      used_sum;
        int      usable_sum;
        int      n_used;
        bit      hit;
        base       = 0;
        used_sum   = 0;
        usable_sum = 0;
        n_used     = 0;
        hit        = 1'b0;
        res        = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (!hit)
            begin
                if (r.command == CMD_ALLOCATE)
                begin
                    if (r.request_size != 0 && occupied[i] == 0 &&
                        part_size[i] >= r.request_size)
                    begin
                        occupied[i]      = r.request_size;
                        res.granted_base = base[ADDR_W-1:0];
                        hit              = 1'b1;
                    end
                end
                else if (base == int'(r.release_base) && occupied[i] != 0)
                begin
                    occupied[i] = '0;
                    hit         = 1'b1;
                end
            end
            base += part_size[i];
        end
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (occupied[i] != 0)
            begin
                used_sum += occupied[i];
                n_used++;
            end
            else
            begin
                usable_sum += part_size[i];
            end
        end
        res.success           = hit;
        res.used_total        = used_sum[ADDR_W-1:0];
        res.used_count        = n_used[COUNT_W-1:0];
        res.free_count        = 3'(NUM_REGS - n_used);
        res.free_total        = (base >= used_sum) ? 14'(base - used_sum) : '0;
        res.free_usable_total = usable_sum[ADDR_W-1:0];
        return res;
    endfunction

    function automatic request_t make_request(command_t cmd, int size, int base);
        request_t r;
        r.command      = cmd;
        r.request_size = size[SIZE_W-1:0];
        r.release_base = base[ADDR_W-1:0];
        return r;
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy !== 1'b0);
        pending_results.push_back(first_fit_step(r));
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(bit is_write, reg_index_t idx, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_sizes;
        logic [PDATA_W-1:0] rdata;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b0, reg_index_t'(i), '0, rdata);
            if (rdata !== PDATA_W'(part_size[i]))
            begin
                $error("partition_size_%0d: expected %0d, actual %0d", i, part_size[i], rdata);
                error_count++;
            end
        end
    endtask

    task automatic write_sizes(int s0, int s1, int s2, int s3);
        logic [PDATA_W-1:0] rdata;
        int                 sizes [NUM_REGS];
        sizes = '{s0, s1, s2, s3};
        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b1, reg_index_t'(i), PDATA_W'(sizes[i]), rdata);
            part_size[i] = sizes[i][SIZE_W-1:0];
        end
        check_sizes();
    endtask

    function automatic int draw_size();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(1, 16);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    task automatic test_register_reset;
        check_sizes();
    endtask

    task automatic test_first_fit_reset_sizes;
        send_request(make_request(CMD_ALLOCATE, 0, 0));
        send_request(make_request(CMD_ALLOCATE, 4095, 16383));
        send_request(make_request(CMD_ALLOCATE, 500, 0));
        send_request(make_request(CMD_ALLOCATE, 1, 0));
        send_request(make_request(CMD_ALLOCATE, 250, 0));
        send_request(make_request(CMD_ALLOCATE, 150, 0));
        send_request(make_request(CMD_ALLOCATE, 100, 0));
        send_request(make_request(CMD_ALLOCATE, 1, 0));
        send_request(make_request(CMD_RELEASE, 4095, 16383));
        send_request(make_request(CMD_RELEASE, 0, 500));
        send_request(make_request(CMD_RELEASE, 0, 500));
        send_request(make_request(CMD_RELEASE, 0, 0));
        send_request(make_request(CMD_RELEASE, 0, 750));
        send_request(make_request(CMD_RELEASE, 0, 900));
    endtask

    // Full sizes cover addresses 0 to 16379; zero sizes then shrink the used
    // partitions below their recorded sizes and give them one shared start.
    task automatic test_size_extremes;
        write_sizes(4095, 4095, 4095, 4095);
        repeat (4) send_request(make_request(CMD_ALLOCATE, 4095, 0));
        send_request(make_request(CMD_ALLOCATE, 1, 0));
        send_request(make_request(CMD_RELEASE, 0, 12285));
        write_sizes(0, 0, 0, 0);
        send_request(make_request(CMD_ALLOCATE, 1, 0));
        repeat (4) send_request(make_request(CMD_RELEASE, 0, 0));
    endtask

    task automatic test_random_phases;
        request_t r;
        int       idx;
        int       base;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_sizes(draw_size(), draw_size(), draw_size(), draw_size());
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                r.request_size = SIZE_W'($urandom_range(0, 4095));
                r.release_base = ADDR_W'($urandom_range(0, 16383));
                if ($urandom_range(0, 9) < 6)
                begin
                    r.command = CMD_ALLOCATE;
                    case ($urandom_range(0, 9))
                        0: r.request_size = '0;
                        1: ;
                        default: r.request_size =
                            SIZE_W'($urandom_range(1, part_size[$urandom_range(0, 3)]));
                    endcase
                end
                else
                begin
                    r.command = CMD_RELEASE;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        idx  = $urandom_range(0, NUM_REGS - 1);
                        base = 0;
                        for (int i = 0; i < idx; i++)
                            base += part_size[i];
                        r.release_base = base[ADDR_W-1:0];
                    end
                end
                send_request(r);
            end
            no_gaps = 1'b0;
        end
    endtask

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                result_t exp;
                exp = pending_results.pop_front();
                check_field("success", exp.success, result.success);
                check_field("granted_base", exp.granted_base, result.granted_base);
                check_field("used_total", exp.used_total, result.used_total);
                check_field("used_count", exp.used_count, result.used_count);
                check_field("free_count", exp.free_count, result.free_count);
                check_field("free_total", exp.free_total, result.free_total);
                check_field("free_usable_total", exp.free_usable_total,
                            result.free_usable_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid === 1'b1 || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            part_size[i] = SIZE_RESET[i];
            occupied[i]  = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_first_fit_reset_sizes();
        test_size_extremes();
        test_random_phases();
        drain();

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> first_fit_partition_allocator.f
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_engine.sv
rtl/core/first_fit_partition_allocator.sv
rtl/core/ffpa_checker.sv
bench/tb.sv
